// ===== sv/tlb_pkg.sv =====
// ============================================================================
// TLB address translation package
// Shared codes, field positions and the set index folding table.
// ============================================================================
package tlb_pkg;

   // Default geometry of the TLB.
   localparam int NUM_SETS_DEF = 32;
   localparam int WAYS_DEF     = 4;

   // Payload widths.
   localparam int ADDR_W   = 32;
   localparam int WORD_W   = 32;
   localparam int FAULT_W  = 4;
   localparam int ASID_W   = 8;
   localparam int RAW_SET_W = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 8;

   // Operation codes.
   localparam logic [1:0] OP_TRANSLATE = 2'd0;
   localparam logic [1:0] OP_WRITE     = 2'd1;
   localparam logic [1:0] OP_READ      = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MMU_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_MODE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_VIRTUAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_ASID   = 3'd3;

   // Fault codes.
   localparam logic [FAULT_W-1:0] FAULT_NONE           = 4'd0;
   localparam logic [FAULT_W-1:0] FAULT_LOAD_ADDR_ERR  = 4'd1;
   localparam logic [FAULT_W-1:0] FAULT_STORE_ADDR_ERR = 4'd2;
   localparam logic [FAULT_W-1:0] FAULT_LOAD_MISS      = 4'd3;
   localparam logic [FAULT_W-1:0] FAULT_STORE_MISS     = 4'd4;
   localparam logic [FAULT_W-1:0] FAULT_LOAD_INVALID   = 4'd5;
   localparam logic [FAULT_W-1:0] FAULT_STORE_INVALID  = 4'd6;
   localparam logic [FAULT_W-1:0] FAULT_LOAD_PROT      = 4'd7;
   localparam logic [FAULT_W-1:0] FAULT_STORE_PROT     = 4'd8;
   localparam logic [FAULT_W-1:0] FAULT_INITIAL_WRITE  = 4'd9;

   // Address area codes taken from vaddr[31:29].
   localparam logic [2:0] AREA_P1   = 3'b100;
   localparam logic [2:0] AREA_P2   = 3'b101;
   localparam logic [2:0] AREA_CTRL = 3'b111;

   // Protection codes of the data word PR field.
   localparam logic [1:0] PR_USER_READ = 2'd2;

   // Bit positions inside the address and data array words.
   localparam int V_BIT  = 8;
   localparam int SZ_BIT = 4;
   localparam int C_BIT  = 3;
   localparam int D_BIT  = 2;
   localparam int SH_BIT = 1;

   // Maps every raw 5-bit set number onto a set that exists.
   typedef logic [31:0][RAW_SET_W-1:0] set_fold_type;

   function automatic set_fold_type set_fold(int num_sets);
      set_fold_type      map;
      logic [RAW_SET_W-1:0] cnt;
      cnt = '0;
      for (int i = 0; i < 32; i++) begin
         map[i] = cnt;
         if (int'(cnt) + 1 >= num_sets) begin
            cnt = '0;
         end else begin
            cnt = cnt + 5'd1;
         end
      end
      return map;
   endfunction

endpackage

// ===== sv/tlb_address_translate.sv =====
// ============================================================================
// TLB address translation
// Pipeline: a request moves from its transfer into stage one, then into the
// response register. Throughput: one request per cycle unless the response
// stalls; the set row is read from the TLB arrays at the request transfer
// and compared in the single stage after it.
// Reset: synchronous, clears the control registers and every entry valid bit
// at once, so all entries read as zero right away; there is no clearing pass.
// ============================================================================
module tlb_address_translate #(
   parameter int NUM_SETS = tlb_pkg::NUM_SETS_DEF,
   parameter int WAYS     = tlb_pkg::WAYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata, low bit up: vaddr[31:0], is_write[32], priv_mode[33],
   // way[35:34], array_word[67:36], zero pad[71:68].
   input  logic [71:0] req_tdata,
   // req_tuser, low bit up: operation[1:0], array_select[2].
   input  logic [2:0]  req_tuser,
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata, low bit up: paddr[31:0], cacheable[32], fault[36:33],
   // read_word[68:37], zero pad[71:69].
   output logic [71:0] rsp_tdata,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [tlb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tlb_pkg::CSR_DAT_W-1:0] csr_data
);

   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam tlb_pkg::set_fold_type SET_FOLD = tlb_pkg::set_fold(NUM_SETS);

   // ------------------------------------------------------------------------
   // Request fields.
   // ------------------------------------------------------------------------
   logic [1:0]  req_op;
   logic [31:0] req_va;
   logic        req_wr;
   logic        req_priv;
   logic        req_dsel;
   logic [1:0]  req_way;
   logic [31:0] req_word;
   logic        req_xfer;
   logic        req_way_ok;
   logic [WAY_W-1:0] req_way_idx;
   logic [tlb_pkg::RAW_SET_W-1:0] req_raw_set;
   logic [SET_W-1:0] req_set;

   assign req_va   = req_tdata[31:0];
   assign req_wr   = req_tdata[32];
   assign req_priv = req_tdata[33];
   assign req_way  = req_tdata[35:34];
   assign req_word = req_tdata[67:36];
   assign req_op   = req_tuser[1:0];
   assign req_dsel = req_tuser[2];

   // ------------------------------------------------------------------------
   // Configuration registers. Writes are always taken; an index beyond the
   // register list is dropped.
   // ------------------------------------------------------------------------
   logic             mmu_enable_ff;
   logic             index_mode_ff;
   logic             single_virtual_ff;
   logic [tlb_pkg::ASID_W-1:0] current_asid_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mmu_enable_ff     <= 1'b0;
         index_mode_ff     <= 1'b0;
         single_virtual_ff <= 1'b0;
         current_asid_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tlb_pkg::CSR_MMU_ENABLE:     mmu_enable_ff     <= csr_data[0];
            tlb_pkg::CSR_INDEX_MODE:     index_mode_ff     <= csr_data[0];
            tlb_pkg::CSR_SINGLE_VIRTUAL: single_virtual_ff <= csr_data[0];
            tlb_pkg::CSR_CURRENT_ASID:   current_asid_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Set index. The raw set number is vaddr[16:12], optionally XORed with the
   // low ASID bits, and is then folded onto the sets that exist. The same
   // index serves translation and array access.
   // ------------------------------------------------------------------------
   assign req_raw_set = req_va[16:12] ^
                        (index_mode_ff ? current_asid_ff[4:0] : 5'd0);
   assign req_set     = SET_FOLD[req_raw_set][SET_W-1:0];
   assign req_way_ok  = (32'(req_way) < WAYS);
   assign req_way_idx = WAY_W'(req_way);

   // ------------------------------------------------------------------------
   // Pipeline control. Stage one holds an item whose set row has been read;
   // the response register parts it from the consumer. A new request is
   // taken whenever stage one is empty or moves on in the same cycle.
   // ------------------------------------------------------------------------
   logic s1_vld_ff;
   logic s1_adv;
   logic rsp_vld_ff;

   assign s1_adv     = !rsp_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || s1_adv;
   assign req_xfer   = req_tvalid && req_tready;

   // ------------------------------------------------------------------------
   // TLB arrays. One row per set holds all ways, so a translation reads the
   // whole set at one address. An array write lands at its own request
   // transfer, so the next request already sees it. The arrays have no reset;
   // the per-entry valid bits below make an unwritten entry read as zero.
   // ------------------------------------------------------------------------
   logic [WAYS-1:0][31:0] tag_mem [NUM_SETS];
   logic [WAYS-1:0][31:0] dat_mem [NUM_SETS];
   logic [NUM_SETS-1:0][WAYS-1:0] tag_vld_ff;
   logic [NUM_SETS-1:0][WAYS-1:0] dat_vld_ff;
   logic array_write;

   assign array_write = req_xfer && (req_op == tlb_pkg::OP_WRITE) && req_way_ok;

   always_ff @(posedge clock) begin
      if (array_write) begin
         if (req_dsel) begin
            dat_mem[req_set][req_way_idx] <= req_word;
         end else begin
            tag_mem[req_set][req_way_idx] <= req_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_vld_ff <= '0;
         dat_vld_ff <= '0;
      end else if (array_write) begin
         if (req_dsel) begin
            dat_vld_ff[req_set][req_way_idx] <= 1'b1;
         end else begin
            tag_vld_ff[req_set][req_way_idx] <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage one registers: the request fields and the registered set row.
   // ------------------------------------------------------------------------
   logic [1:0]  s1_op_ff;
   logic [31:0] s1_va_ff;
   logic        s1_wr_ff;
   logic        s1_priv_ff;
   logic        s1_dsel_ff;
   logic [1:0]  s1_way_ff;
   logic [WAYS-1:0][31:0] s1_tag_row_ff;
   logic [WAYS-1:0][31:0] s1_dat_row_ff;
   logic [WAYS-1:0]       s1_tag_vld_ff;
   logic [WAYS-1:0]       s1_dat_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_vld_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff      <= req_op;
         s1_va_ff      <= req_va;
         s1_wr_ff      <= req_wr;
         s1_priv_ff    <= req_priv;
         s1_dsel_ff    <= req_dsel;
         s1_way_ff     <= req_way;
         s1_tag_row_ff <= tag_mem[req_set];
         s1_dat_row_ff <= dat_mem[req_set];
         s1_tag_vld_ff <= tag_vld_ff[req_set];
         s1_dat_vld_ff <= dat_vld_ff[req_set];
      end
   end

   // ------------------------------------------------------------------------
   // Way compare. Every way of the set is compared in parallel; the VPN bits
   // 11:10 count only for 1K pages, and the ASID is ignored for shared
   // entries and for privileged accesses in single-virtual mode. The
   // lowest-numbered matching way wins.
   // ------------------------------------------------------------------------
   logic [WAYS-1:0][31:0] tag_eff;
   logic [WAYS-1:0][31:0] dat_eff;
   logic [WAYS-1:0]       way_match;
   logic                  hit;
   logic [31:0]           hit_tag;
   logic [31:0]           hit_dat;

   always_comb begin
      hit     = 1'b0;
      hit_tag = '0;
      hit_dat = '0;
      for (int w = 0; w < WAYS; w++) begin
         tag_eff[w]   = s1_tag_vld_ff[w] ? s1_tag_row_ff[w] : 32'd0;
         dat_eff[w]   = s1_dat_vld_ff[w] ? s1_dat_row_ff[w] : 32'd0;
         way_match[w] = (s1_va_ff[31:17] == tag_eff[w][31:17]) &&
                        (dat_eff[w][tlb_pkg::SZ_BIT] ||
                         (s1_va_ff[11:10] == tag_eff[w][11:10])) &&
                        (dat_eff[w][tlb_pkg::SH_BIT] ||
                         (s1_priv_ff && single_virtual_ff) ||
                         (tag_eff[w][7:0] == current_asid_ff));
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (way_match[w]) begin
            hit     = 1'b1;
            hit_tag = tag_eff[w];
            hit_dat = dat_eff[w];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result. Translation first sorts the address by area; only mapped areas
   // use the compare above. A faulting translation returns a zero address.
   // ------------------------------------------------------------------------
   logic [31:0] res_paddr_in;
   logic        res_cacheable_in;
   logic [tlb_pkg::FAULT_W-1:0] res_fault_in;
   logic [31:0] res_read_word_in;
   logic [tlb_pkg::FAULT_W-1:0] prot_fault;
   logic [2:0]  area;
   logic [1:0]  hit_pr;
   logic        hit_dirty;
   logic        s1_way_ok;
   logic [WAY_W-1:0] s1_way_idx;

   assign area       = s1_va_ff[31:29];
   assign hit_pr     = hit_dat[6:5];
   assign hit_dirty  = hit_dat[tlb_pkg::D_BIT];
   assign s1_way_ok  = (32'(s1_way_ff) < WAYS);
   assign s1_way_idx = WAY_W'(s1_way_ff);

   // Protection and first-write check of a valid matching entry.
   always_comb begin
      prot_fault = tlb_pkg::FAULT_NONE;
      if (!s1_priv_ff) begin
         if (!hit_pr[1]) begin
            prot_fault = s1_wr_ff ? tlb_pkg::FAULT_STORE_PROT
                                  : tlb_pkg::FAULT_LOAD_PROT;
         end else if (hit_pr == tlb_pkg::PR_USER_READ && s1_wr_ff) begin
            prot_fault = tlb_pkg::FAULT_STORE_PROT;
         end else if (s1_wr_ff && !hit_dirty) begin
            prot_fault = tlb_pkg::FAULT_INITIAL_WRITE;
         end
      end else if (s1_wr_ff) begin
         if (!hit_pr[0]) begin
            prot_fault = tlb_pkg::FAULT_STORE_PROT;
         end else if (!hit_dirty) begin
            prot_fault = tlb_pkg::FAULT_INITIAL_WRITE;
         end
      end
   end

   always_comb begin
      res_paddr_in     = '0;
      res_cacheable_in = 1'b0;
      res_fault_in     = tlb_pkg::FAULT_NONE;
      res_read_word_in = '0;
      case (s1_op_ff)
         tlb_pkg::OP_TRANSLATE: begin
            if (area == tlb_pkg::AREA_CTRL) begin
               // Control area passes through uncached.
               res_paddr_in = s1_va_ff;
            end else if (!mmu_enable_ff) begin
               res_paddr_in     = {3'b000, s1_va_ff[28:0]};
               res_cacheable_in = 1'b1;
            end else if (!s1_priv_ff && s1_va_ff[31]) begin
               res_fault_in = s1_wr_ff ? tlb_pkg::FAULT_STORE_ADDR_ERR
                                       : tlb_pkg::FAULT_LOAD_ADDR_ERR;
            end else if (s1_priv_ff && area == tlb_pkg::AREA_P1) begin
               res_paddr_in     = {1'b0, s1_va_ff[30:0]};
               res_cacheable_in = 1'b1;
            end else if (s1_priv_ff && area == tlb_pkg::AREA_P2) begin
               res_paddr_in = {3'b000, s1_va_ff[28:0]};
            end else if (!hit) begin
               res_fault_in = s1_wr_ff ? tlb_pkg::FAULT_STORE_MISS
                                       : tlb_pkg::FAULT_LOAD_MISS;
            end else if (!(hit_tag[tlb_pkg::V_BIT] || hit_dat[tlb_pkg::V_BIT])) begin
               res_fault_in = s1_wr_ff ? tlb_pkg::FAULT_STORE_INVALID
                                       : tlb_pkg::FAULT_LOAD_INVALID;
            end else if (prot_fault != tlb_pkg::FAULT_NONE) begin
               res_fault_in = prot_fault;
            end else begin
               if (hit_dat[tlb_pkg::SZ_BIT]) begin
                  res_paddr_in = {3'b000, hit_dat[28:12], s1_va_ff[11:0]};
               end else begin
                  res_paddr_in = {3'b000, hit_dat[28:10], s1_va_ff[9:0]};
               end
               res_cacheable_in = hit_dat[tlb_pkg::C_BIT];
            end
         end
         tlb_pkg::OP_READ: begin
            if (s1_way_ok) begin
               res_read_word_in = s1_dsel_ff ? dat_eff[s1_way_idx]
                                             : tag_eff[s1_way_idx];
            end
         end
         default: begin
            // Array writes and the unused code return all zeros.
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Response register.
   // ------------------------------------------------------------------------
   logic [31:0] rsp_paddr_ff;
   logic        rsp_cacheable_ff;
   logic [tlb_pkg::FAULT_W-1:0] rsp_fault_ff;
   logic [31:0] rsp_read_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_vld_ff) begin
         rsp_paddr_ff     <= res_paddr_in;
         rsp_cacheable_ff <= res_cacheable_in;
         rsp_fault_ff     <= res_fault_in;
         rsp_read_word_ff <= res_read_word_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_read_word_ff, rsp_fault_ff,
                        rsp_cacheable_ff, rsp_paddr_ff};

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
   // A request transfer always leaves an item in stage one.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_vld_ff)
      else $error("request transfer did not reach stage one");

   // An item in stage one moves into a free response register.
   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !rsp_tvalid |=> rsp_tvalid)
      else $error("stage one item was not passed to the response register");

   // A stalled response keeps the item behind it in stage one.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && rsp_tvalid && !rsp_tready |=> s1_vld_ff && $stable(s1_va_ff))
      else $error("stage one item lost while the response was stalled");

   // A faulting response carries neither an address nor a cacheable flag.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[36:33] != tlb_pkg::FAULT_NONE |->
         rsp_tdata[32:0] == 33'd0)
      else $error("faulting response carries an address");
`endif

endmodule

// ===== dv/tb_top.sv =====
// ============================================================================
// TLB address translation testbench
// Drives request transfers and register writes into the TLB block and checks
// every response against a cycle-free predictor of the TLB and its registers.
// A directed opening walks every address area and every fault code but the
// load protection fault. Randomized phases follow under changing register
// settings, mostly as entry-fill then lookup sequences with random content.
// Both channels idle and stall in random bursts.
// ============================================================================
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SETS    = tlb_pkg::NUM_SETS_DEF;
   localparam int WAYS        = tlb_pkg::WAYS_DEF;
   localparam int CYCLE_LIMIT = 150000;
   // Number of final requests that are sent and drained without any idling.
   localparam int CALM_TAIL   = 50;

   // Codes of the data word PR field, the operation field and the address area that the package does not name.
   localparam logic [1:0] PR_PRIV_RO = 2'd0;
   localparam logic [1:0] PR_PRIV_RW = 2'd1;
   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam logic [2:0] AREA_P3    = 3'b110;
   // vaddr bits that select the set for both lookups and array accesses.
   localparam logic [31:0] SET_FIELD = 32'h0001_F000;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] vaddr;
      logic        is_write;
      logic        priv;
      logic        asel;
      logic [1:0]  way;
      logic [31:0] word;
   } tlb_req_type;

   typedef struct packed {
      logic [31:0]                 paddr;
      logic                        cacheable;
      logic [tlb_pkg::FAULT_W-1:0] fault;
      logic [31:0]                 read_word;
   } tlb_rsp_type;

   typedef enum logic {KIND_REQUEST, KIND_CSR_WRITE} stim_kind_type;

   typedef struct {
      stim_kind_type                 kind;
      tlb_req_type                   req;
      logic [tlb_pkg::CSR_IDX_W-1:0] csr_idx;
      logic [tlb_pkg::CSR_DAT_W-1:0] csr_val;
   } stim_type;

   // ------------------------------------------------------------------------
   // Clock, reset and the signals of the block.
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [71:0]                   req_tdata  = '0;
   logic [2:0]                    req_tuser  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [71:0]                   rsp_tdata;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [tlb_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [tlb_pkg::CSR_DAT_W-1:0] csr_data   = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tlb_address_translate i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------------------------
   // Predictor state: a mirror of both TLB arrays and of the registers, as
   // they stand after every accepted transfer.
   // ------------------------------------------------------------------------
   logic [31:0] tlb_tag_mirror  [NUM_SETS*WAYS];
   logic [31:0] tlb_data_mirror [NUM_SETS*WAYS];
   logic        cfg_mmu_on;
   logic        cfg_asid_xor;
   logic        cfg_single_vs;
   logic [7:0]  cfg_asid;

   stim_type    stim_q[$];       // pending stimulus, filled before reset ends
   tlb_rsp_type mmu_reply_q[$];  // responses still owed by the block, oldest first

   // ASID register value the stimulus generator assumes once its write lands.
   logic [7:0] plan_asid;

   int total_reqs;
   int translate_reqs;
   int csr_writes;
   int req_sent;
   int rsp_seen;
   int mismatches;
   int cycle_cnt;
   int fault_mix [16];

   // Computes the response to one request and applies its effect on the
   // mirrored arrays. Called once per accepted request transfer, in order.
   function automatic tlb_rsp_type mmu_reply(tlb_req_type r);
      tlb_rsp_type o;
      logic [4:0]  set_no;
      int          base;
      int          hit;
      logic [31:0] tag_w;
      logic [31:0] dat_w;
      logic [1:0]  pr;
      logic [3:0]  flt;
      o      = '0;
      set_no = r.vaddr[16:12] ^ (cfg_asid_xor ? cfg_asid[4:0] : 5'd0);
      base   = (int'(set_no) % NUM_SETS) * WAYS;
      case (r.op)
         tlb_pkg::OP_TRANSLATE: begin
            if (r.vaddr[31:29] == tlb_pkg::AREA_CTRL) begin
               // The control area is never translated and never cached.
               o.paddr = r.vaddr;
            end else if (!cfg_mmu_on) begin
               o.paddr     = {3'b000, r.vaddr[28:0]};
               o.cacheable = 1'b1;
            end else if (!r.priv && r.vaddr[31]) begin
               o.fault = r.is_write ? tlb_pkg::FAULT_STORE_ADDR_ERR
                                    : tlb_pkg::FAULT_LOAD_ADDR_ERR;
            end else if (r.priv && r.vaddr[31:29] == tlb_pkg::AREA_P1) begin
               o.paddr     = {1'b0, r.vaddr[30:0]};
               o.cacheable = 1'b1;
            end else if (r.priv && r.vaddr[31:29] == tlb_pkg::AREA_P2) begin
               o.paddr = {3'b000, r.vaddr[28:0]};
            end else begin
               // Mapped area: the lowest matching way of the set wins.
               hit = -1;
               for (int w = 0; w < WAYS; w++) begin
                  tag_w = tlb_tag_mirror[base + w];
                  dat_w = tlb_data_mirror[base + w];
                  if (hit < 0 && tag_w[31:17] == r.vaddr[31:17] &&
                      (dat_w[tlb_pkg::SZ_BIT] || tag_w[11:10] == r.vaddr[11:10]) &&
                      (dat_w[tlb_pkg::SH_BIT] || (r.priv && cfg_single_vs) ||
                       tag_w[7:0] == cfg_asid)) begin
                     hit = base + w;
                  end
               end
               flt = tlb_pkg::FAULT_NONE;
               if (hit < 0) begin
                  flt = r.is_write ? tlb_pkg::FAULT_STORE_MISS
                                   : tlb_pkg::FAULT_LOAD_MISS;
               end else begin
                  tag_w = tlb_tag_mirror[hit];
                  dat_w = tlb_data_mirror[hit];
                  pr    = dat_w[6:5];
                  if (!(tag_w[tlb_pkg::V_BIT] || dat_w[tlb_pkg::V_BIT])) begin
                     flt = r.is_write ? tlb_pkg::FAULT_STORE_INVALID
                                      : tlb_pkg::FAULT_LOAD_INVALID;
                  end else if (!r.priv) begin
                     if (pr == PR_PRIV_RO || pr == PR_PRIV_RW) begin
                        flt = r.is_write ? tlb_pkg::FAULT_STORE_PROT
                                         : tlb_pkg::FAULT_LOAD_PROT;
                     end else if (pr == tlb_pkg::PR_USER_READ && r.is_write) begin
                        flt = tlb_pkg::FAULT_STORE_PROT;
                     end else if (r.is_write && !dat_w[tlb_pkg::D_BIT]) begin
                        flt = tlb_pkg::FAULT_INITIAL_WRITE;
                     end
                  end else if (r.is_write) begin
                     if (pr == PR_PRIV_RO || pr == tlb_pkg::PR_USER_READ) begin
                        flt = tlb_pkg::FAULT_STORE_PROT;
                     end else if (!dat_w[tlb_pkg::D_BIT]) begin
                        flt = tlb_pkg::FAULT_INITIAL_WRITE;
                     end
                  end
               end
               if (flt != tlb_pkg::FAULT_NONE) begin
                  o.fault = flt;
               end else begin
                  o.paddr = dat_w[tlb_pkg::SZ_BIT]
                            ? {3'b000, dat_w[28:12], r.vaddr[11:0]}
                            : {3'b000, dat_w[28:10], r.vaddr[9:0]};
                  o.cacheable = dat_w[tlb_pkg::C_BIT];
               end
            end
         end
         tlb_pkg::OP_WRITE: begin
            if (r.way < WAYS) begin
               if (r.asel) begin
                  tlb_data_mirror[base + r.way] = r.word;
               end else begin
                  tlb_tag_mirror[base + r.way] = r.word;
               end
            end
         end
         tlb_pkg::OP_READ: begin
            if (r.way < WAYS) begin
               o.read_word = r.asel ? tlb_data_mirror[base + r.way]
                                    : tlb_tag_mirror[base + r.way];
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   task automatic add_req(input logic [1:0] op, input logic [31:0] va,
                          input logic wr, input logic pv, input logic sel,
                          input logic [1:0] w, input logic [31:0] word);
      stim_type s;
      s.kind    = KIND_REQUEST;
      s.req     = '{op: op, vaddr: va, is_write: wr, priv: pv, asel: sel,
                    way: w, word: word};
      s.csr_idx = '0;
      s.csr_val = '0;
      stim_q.push_back(s);
      total_reqs++;
      if (op == tlb_pkg::OP_TRANSLATE) begin
         translate_reqs++;
      end
   endtask

   // Queues a write of all four registers. The driver holds each of them
   // back until the block has returned every owed response.
   task automatic set_mode(input logic mmu, input logic xor_idx, input logic sv,
                           input logic [7:0] asid);
      stim_type s;
      s.kind    = KIND_CSR_WRITE;
      s.req     = '0;
      s.csr_idx = tlb_pkg::CSR_MMU_ENABLE;
      s.csr_val = {7'd0, mmu};
      stim_q.push_back(s);
      s.csr_idx = tlb_pkg::CSR_INDEX_MODE;
      s.csr_val = {7'd0, xor_idx};
      stim_q.push_back(s);
      s.csr_idx = tlb_pkg::CSR_SINGLE_VIRTUAL;
      s.csr_val = {7'd0, sv};
      stim_q.push_back(s);
      s.csr_idx = tlb_pkg::CSR_CURRENT_ASID;
      s.csr_val = asid;
      stim_q.push_back(s);
      plan_asid = asid;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus and end of run. The whole queue is built at time zero; the
   // driver then consumes it at its own pace.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [31:0] va;
      logic [31:0] tag;
      logic [31:0] dat;
      logic [31:0] tva;
      logic [2:0]  area;
      logic [7:0]  asid_e;
      logic [1:0]  w;
      int          vsel;
      int          target;
      int          k;

      total_reqs     = 0;
      translate_reqs = 0;
      plan_asid      = '0;

      // Registers are at reset: the MMU is off and only area handling shows.
      add_req(tlb_pkg::OP_TRANSLATE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 2'd3,
              32'hFFFF_FFFF);
      add_req(tlb_pkg::OP_TRANSLATE, 32'hDFFF_FFFF, 1'b1, 1'b0, 1'b0, 2'd0, 32'h0);
      add_req(OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 2'd3, 32'hFFFF_FFFF);
      // An entry that was never written reads back as zero after reset.
      add_req(tlb_pkg::OP_READ, 32'h0001_F000, 1'b0, 1'b0, 1'b0, 2'd3, 32'h0);
      // Set 1, way 0: 4K page, user read/write, clean, cacheable. The valid
      // bit sits only in the data word.
      add_req(tlb_pkg::OP_WRITE, 32'h0040_1000, 1'b0, 1'b0, 1'b0, 2'd0, 32'h0040_005A);
      add_req(tlb_pkg::OP_WRITE, 32'h0040_1000, 1'b0, 1'b0, 1'b1, 2'd0, 32'h1234_5178);
      // Set 2, way 3: shared 1K page, user read-only, valid bit only in the
      // address word, under a foreign ASID.
      add_req(tlb_pkg::OP_WRITE, 32'h6000_2C00, 1'b0, 1'b0, 1'b0, 2'd3, 32'h6000_0D11);
      add_req(tlb_pkg::OP_WRITE, 32'h6000_2C00, 1'b0, 1'b0, 1'b1, 2'd3, 32'h0ABC_D442);
      // Set 3, way 1: matches but is valid in neither word.
      add_req(tlb_pkg::OP_WRITE, 32'h0080_3000, 1'b0, 1'b0, 1'b0, 2'd1, 32'h0080_005A);
      add_req(tlb_pkg::OP_READ, 32'h0040_1000, 1'b0, 1'b0, 1'b1, 2'd0, 32'h0);

      set_mode(1'b1, 1'b0, 1'b0, 8'h5A);
      add_req(tlb_pkg::OP_TRANSLATE, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'hC000_0000, 1'b1, 1'b0, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'h9FFF_FFFF, 1'b0, 1'b1, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'hA000_0000, 1'b1, 1'b1, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'h0040_1ABC, 1'b0, 1'b0, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'h0040_1FFF, 1'b1, 1'b0, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'h0040_5000, 1'b0, 1'b0, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'h7FFF_F000, 1'b1, 1'b0, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'h6000_2DED, 1'b0, 1'b0, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'h6000_2DED, 1'b1, 1'b0, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'h6000_2C00, 1'b1, 1'b1, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'h0080_3000, 1'b0, 1'b0, 1'b0, 2'd0, 32'h0);
      add_req(tlb_pkg::OP_TRANSLATE, 32'h0080_3000, 1'b1, 1'b0, 1'b0, 2'd0, 32'h0);

      // Random phases. The first three pin the register extremes; later
      // ones mostly keep the MMU on, where the lookup logic does its work.
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: set_mode(1'b1, 1'b1, 1'b1, 8'hFF);
            1: set_mode(1'b1, 1'b0, 1'b0, 8'h00);
            2: set_mode(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                        8'($urandom));
            default: set_mode($urandom_range(3) != 0, 1'($urandom_range(1)),
                              1'($urandom_range(1)), 8'($urandom));
         endcase
         target = total_reqs + 60;
         while (total_reqs < target) begin
            if ($urandom_range(99) < 70) begin
               // Fill one entry with random content, then look it up. Most
               // entries carry the running ASID so that lookups get past the
               // tag compare; the rest exercise the shared and
               // single-virtual paths or simply miss.
               area   = ($urandom_range(4) == 0) ? AREA_P3 : 3'($urandom_range(3));
               va     = {area, 29'($urandom)};
               asid_e = ($urandom_range(4) == 0) ? 8'($urandom) : plan_asid;
               vsel   = $urandom_range(9);
               w      = 2'($urandom_range(3));
               tag    = (va & 32'hFFFE_0C00) | ($urandom & 32'h0001_F200) | asid_e;
               tag[tlb_pkg::V_BIT] = (vsel >= 1 && vsel <= 3) || vsel >= 7;
               dat    = $urandom;
               dat[tlb_pkg::V_BIT]  = vsel >= 4;
               dat[tlb_pkg::SH_BIT] = $urandom_range(3) == 0;
               add_req(tlb_pkg::OP_WRITE, ($urandom & ~SET_FIELD) | (va & SET_FIELD),
                       1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, w, tag);
               add_req(tlb_pkg::OP_WRITE, ($urandom & ~SET_FIELD) | (va & SET_FIELD),
                       1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1, w, dat);
               if ($urandom_range(2) == 0) begin
                  add_req(tlb_pkg::OP_READ, va, 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)), w, $urandom);
               end
               repeat ($urandom_range(2, 4)) begin
                  tva = {va[31:10], 10'($urandom)};
                  if ($urandom_range(4) == 0) begin
                     k      = $urandom_range(31, 10);
                     tva[k] = ~tva[k];
                  end
                  add_req(tlb_pkg::OP_TRANSLATE, tva, 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          2'($urandom_range(3)), $urandom);
               end
            end else begin
               // Unstructured traffic: any operation with any field values.
               add_req(($urandom_range(1) == 0) ? tlb_pkg::OP_TRANSLATE
                                                : 2'($urandom_range(3)),
                       $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 2'($urandom_range(3)), $urandom);
            end
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait until everything was sent, every response came back, and a few
      // quiet cycles passed in which nothing further may appear.
      while (stim_q.size() != 0 || req_tvalid || csr_valid) @(posedge clock);
      while (rsp_seen != req_sent) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mmu_reply_q.size() != 0) begin
         $display("%0d expected responses never arrived", mmu_reply_q.size());
         mismatches++;
      end
      $display("Run covered %0d requests (%0d translations) and %0d register writes.",
               req_sent, translate_reqs, csr_writes);
      $display({"Translation outcomes: %0d clean, %0d address error, %0d miss, ",
                "%0d invalid, %0d protection, %0d first write."},
               fault_mix[0], fault_mix[1] + fault_mix[2], fault_mix[3] + fault_mix[4],
               fault_mix[5] + fault_mix[6], fault_mix[7] + fault_mix[8], fault_mix[9]);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver. Presents request transfers from the stimulus queue and predicts
   // each response at the edge where its transfer completes. Register writes
   // wait until the block has drained, which also gives the sender a full
   // pause until every expected response has come.
   // ------------------------------------------------------------------------
   int gap_left;
   int gap_pct;
   int quiet_cycles;
   tlb_req_type cur_req;

   always @(posedge clock) begin : driver
      logic        nxt_valid;
      logic        nxt_csr;
      stim_type    s;
      tlb_rsp_type p;
      if (reset) begin
         req_tvalid   <= 1'b0;
         req_tdata    <= '0;
         req_tuser    <= '0;
         csr_valid    <= 1'b0;
         csr_index    <= '0;
         csr_data     <= '0;
         gap_left     = 0;
         gap_pct      = 0;
         quiet_cycles = 0;
         req_sent     = 0;
         csr_writes   = 0;
         cur_req      = '0;
         cfg_mmu_on    = 1'b0;
         cfg_asid_xor  = 1'b0;
         cfg_single_vs = 1'b0;
         cfg_asid      = '0;
         foreach (tlb_tag_mirror[i]) begin
            tlb_tag_mirror[i]  = '0;
            tlb_data_mirror[i] = '0;
         end
         foreach (fault_mix[i]) begin
            fault_mix[i] = 0;
         end
      end else begin
         nxt_valid = req_tvalid;
         nxt_csr   = csr_valid;
         if (req_tvalid && req_tready) begin
            p = mmu_reply(cur_req);
            mmu_reply_q.push_back(p);
            if (cur_req.op == tlb_pkg::OP_TRANSLATE) begin
               fault_mix[p.fault]++;
            end
            req_sent++;
            nxt_valid = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tlb_pkg::CSR_MMU_ENABLE:     cfg_mmu_on    = csr_data[0];
               tlb_pkg::CSR_INDEX_MODE:     cfg_asid_xor  = csr_data[0];
               tlb_pkg::CSR_SINGLE_VIRTUAL: cfg_single_vs = csr_data[0];
               tlb_pkg::CSR_CURRENT_ASID:   cfg_asid      = csr_data;
               default: begin
               end
            endcase
            csr_writes++;
            nxt_csr = 1'b0;
         end

         // rsp_seen is updated by the monitor with a nonblocking assignment,
         // so this compares against the count as of the previous edge.
         if (req_sent == rsp_seen && !req_tvalid) begin
            quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end

         if (!nxt_valid && !nxt_csr && stim_q.size() != 0) begin
            if (stim_q[0].kind == KIND_CSR_WRITE) begin
               // Every sent request has been answered and none is pending, so the
               // block is idle when the register write goes out.
               if (quiet_cycles >= 3) begin
                  s = stim_q.pop_front();
                  csr_index <= s.csr_idx;
                  csr_data  <= s.csr_val;
                  nxt_csr   = 1'b1;
                  case ($urandom_range(2))
                     0: gap_pct = 0;
                     1: gap_pct = 10;
                     default: gap_pct = 35;
                  endcase
               end
            end else if (gap_left > 0) begin
               gap_left--;
            end else if (req_sent < total_reqs - CALM_TAIL &&
                         $urandom_range(99) < gap_pct) begin
               // Start an idle burst that includes this cycle.
               gap_left = $urandom_range(0, 5);
            end else begin
               s       = stim_q.pop_front();
               cur_req = s.req;
               req_tdata <= {4'b0000, s.req.word, s.req.way, s.req.priv,
                             s.req.is_write, s.req.vaddr};
               req_tuser <= {s.req.asel, s.req.op};
               nxt_valid = 1'b1;
            end
         end
         req_tvalid <= nxt_valid;
         csr_valid  <= nxt_csr;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. Takes each response transfer, compares it field by field with
   // the oldest prediction, and throttles rsp_tready in random stall bursts.
   // ------------------------------------------------------------------------
   int stall_left;
   int stall_pct;

   always @(posedge clock) begin : monitor
      tlb_rsp_type got;
      tlb_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_seen   <= 0;
         stall_left = 0;
         stall_pct  = 0;
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.paddr     = rsp_tdata[31:0];
            got.cacheable = rsp_tdata[32];
            got.fault     = rsp_tdata[36:33];
            got.read_word = rsp_tdata[68:37];
            if (mmu_reply_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display({"response %0d arrived with none expected: ",
                            "paddr=%h c=%b fault=%0d word=%h"},
                           rsp_seen, got.paddr, got.cacheable, got.fault, got.read_word);
               end
            end else begin
               want = mmu_reply_q.pop_front();
               if (got.paddr !== want.paddr || got.cacheable !== want.cacheable ||
                   got.fault !== want.fault || got.read_word !== want.read_word) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("response %0d differs: expected paddr=%h c=%b fault=%0d word=%h",
                              rsp_seen, want.paddr, want.cacheable, want.fault,
                              want.read_word);
                     $display("                      actual   paddr=%h c=%b fault=%0d word=%h",
                              got.paddr, got.cacheable, got.fault, got.read_word);
                  end
               end
            end
            rsp_seen <= rsp_seen + 1;
            // Change the stall pressure every 64 responses.
            if (rsp_seen % 64 == 63) begin
               case ($urandom_range(2))
                  0: stall_pct = 0;
                  1: stall_pct = 10;
                  default: stall_pct = 35;
               endcase
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_seen < total_reqs - CALM_TAIL &&
                      $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(0, 5);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog. The limit is many times the slowest legal run: every request
   // waiting out a full idle burst, a full stall burst and the latency.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles: %0d of %0d requests sent, %0d responses seen",
                  cycle_cnt, req_sent, total_reqs, rsp_seen);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      cycle_cnt = 0;
   end

endmodule

// ===== tlb_address_translate.f =====
sv/tlb_pkg.sv
sv/tlb_address_translate.sv
dv/tb_top.sv
